// ===== hw/rtl/mavt_pkg.sv =====
package mavt_pkg;

  // Default widths of the angle and of the turn counter.
  localparam int ANGLE_BITS_DEF = 12;
  localparam int TURN_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int ANGLE_W = 12;
  localparam int TIME_W  = 32;
  localparam int TURN_W  = 32;
  localparam int POS_W   = 44;
  localparam int VEL_W   = 32;
  localparam int THR_W   = 12;
  localparam int INTV_W  = 20;
  localparam int CFG_DW  = 20;
  localparam int CFG_AW  = 1;

  // Position change magnitude and its product with the scale factor.
  localparam int MAG_W = POS_W + 1;
  // One million is 2^6 * 15625; the multiplier walks the 14 bits of 15625.
  localparam int K_W   = 14;
  localparam logic [K_W-1:0] K_ODD = 14'd15625;
  localparam int K_SHIFT = 6;
  localparam int ACC_W = MAG_W + K_W;
  localparam int DIV_STEPS = 32;

  // Register indexes.
  localparam logic [CFG_AW-1:0] REG_WRAP_THRESHOLD   = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DEFAULT_INTERVAL = 1'b1;

  localparam logic [THR_W-1:0]  WRAP_THRESHOLD_RST   = 12'd3277;
  localparam logic [INTV_W-1:0] DEFAULT_INTERVAL_RST = 20'd1000;

  typedef enum logic [1:0] {
    T_IDLE,
    T_DELTA,
    T_WAIT,
    T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    V_IDLE,
    V_MUL,
    V_CHECK,
    V_DIV,
    V_DONE
  } vel_state_t;

endpackage

// ===== hw/rtl/mavt_vel.sv =====
module mavt_vel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mavt_pkg::MAG_W-1:0]  mag,
  input  logic                        neg,
  input  logic [mavt_pkg::TIME_W-1:0] dt,
  output logic                        done,
  output logic [mavt_pkg::VEL_W-1:0]  velocity
);

  localparam int AW = mavt_pkg::ACC_W;
  localparam int TW = mavt_pkg::TIME_W;
  localparam int VW = mavt_pkg::VEL_W;
  localparam int LW = AW - TW - mavt_pkg::K_SHIFT + 1;

  mavt_pkg::vel_state_t state, state_next;

  logic [mavt_pkg::MAG_W-1:0] mag_r;
  logic                       neg_r;
  logic [TW-1:0]              dt_r;
  logic [AW-1:0]              acc;
  logic [TW-1:0]              rem;
  logic [TW-1:0]              num;
  logic [TW-1:0]              quo;
  logic                       sat;
  logic [3:0]                 mcnt;
  logic [4:0]                 dcnt;

  logic                       kbit;
  logic [TW:0]                hi;
  logic [TW:0]                shifted;
  logic                       fits;
  logic [VW-1:0]              limit;
  logic [VW-1:0]              res;

  assign kbit    = mavt_pkg::K_ODD[4'(mavt_pkg::K_W - 1) - mcnt];
  assign hi      = (TW + 1)'(acc[AW-1:LW - 1 + mavt_pkg::K_SHIFT - 1 + TW - TW]);
  assign shifted = {rem, num[TW-1]};
  assign fits    = shifted >= {1'b0, dt_r};
  assign limit   = neg_r ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  assign res     = (sat || (quo > limit)) ? limit : quo;
  assign done    = (state == mavt_pkg::V_DONE);
  assign velocity = neg_r ? (VW)'(~res + 1'b1) : res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mavt_pkg::V_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mavt_pkg::V_IDLE: begin
        if (start) state_next = mavt_pkg::V_MUL;
      end
      mavt_pkg::V_MUL: begin
        if (mcnt == 4'(mavt_pkg::K_W - 1)) state_next = mavt_pkg::V_CHECK;
      end
      mavt_pkg::V_CHECK: begin
        state_next = (hi >= {1'b0, dt_r}) ? mavt_pkg::V_DONE : mavt_pkg::V_DIV;
      end
      mavt_pkg::V_DIV: begin
        if (dcnt == 5'(mavt_pkg::DIV_STEPS - 1)) state_next = mavt_pkg::V_DONE;
      end
      mavt_pkg::V_DONE: begin
        state_next = mavt_pkg::V_IDLE;
      end
      default: begin
        state_next = mavt_pkg::V_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      mavt_pkg::V_IDLE: begin
        mag_r <= mag;
        neg_r <= neg;
        dt_r  <= dt;
        acc   <= '0;
        mcnt  <= '0;
        sat   <= 1'b0;
      end
      mavt_pkg::V_MUL: begin
        // MSB-first shift and add over the bits of the odd factor.
        acc  <= {acc[AW-2:0], 1'b0} + (kbit ? AW'(mag_r) : '0);
        mcnt <= mcnt + 4'd1;
      end
      mavt_pkg::V_CHECK: begin
        // The quotient fits in 32 bits only when the upper part is below the divisor.
        sat  <= (hi >= {1'b0, dt_r});
        rem  <= hi[TW-1:0];
        num  <= {acc[TW-mavt_pkg::K_SHIFT-1:0], {mavt_pkg::K_SHIFT{1'b0}}};
        quo  <= '0;
        dcnt <= '0;
      end
      mavt_pkg::V_DIV: begin
        rem  <= fits ? TW'(shifted - {1'b0, dt_r}) : shifted[TW-1:0];
        quo  <= {quo[TW-2:0], fits};
        num  <= {num[TW-2:0], 1'b0};
        dcnt <= dcnt + 5'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/multiturn_angle_velocity_tracker_core.sv =====
// Multi-turn angle and velocity tracker. Each input word carries one absolute
// angle sample and its free-running microsecond timestamp; each one produces
// exactly one output word with the signed turn count, the multi-turn position
// (turns times 2^ANGLE_BITS plus the angle, 44 bits) and the velocity in counts
// per second, truncated toward zero and saturated to 32 bits. A jump between
// consecutive angles larger than wrap_threshold is taken as a turn crossing.
// The first sample after reset only primes the tracker and reports velocity
// zero. A zero elapsed time is replaced by default_interval_us (or by one
// microsecond if that register holds zero). The block works on one word at a
// time: a word with a velocity goes from acceptance to the output register
// through a 14-step shift-and-add multiply by the scale factor and a 32-step
// bit-serial restoring divide by the elapsed time; a saturating word skips
// the divide, and the first sample skips the velocity unit altogether.
// The output register lets the next word be accepted while a finished
// result waits to be taken. Configuration writes are expected only while the
// block is idle.
module multiturn_angle_velocity_tracker_core #(
  parameter int ANGLE_BITS = mavt_pkg::ANGLE_BITS_DEF,
  parameter int TURN_BITS  = mavt_pkg::TURN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Slave side, input word.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0: angle_count[11:0], timestamp_us[43:12], zero pad.
  input  logic [47:0]                   s_tdata,
  // Master side, result word.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: turn_count[31:0], position[75:32], velocity[107:76],
  // zero pad.
  output logic [111:0]                  m_tdata,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [mavt_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [mavt_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int PW  = mavt_pkg::POS_W;
  localparam int TW  = mavt_pkg::TIME_W;
  localparam int CMW = (ANGLE_BITS + 1 > mavt_pkg::THR_W) ? ANGLE_BITS + 1
                                                          : mavt_pkg::THR_W;

  mavt_pkg::top_state_t state, state_next;

  // Configuration registers.
  logic [mavt_pkg::THR_W-1:0]  wrap_threshold;
  logic [mavt_pkg::INTV_W-1:0] default_interval_us;

  // Tracker state.
  logic                  primed;
  logic [ANGLE_BITS-1:0] last_angle;
  logic [TURN_BITS-1:0]  turns;
  logic [PW-1:0]         last_position;
  logic [TW-1:0]         last_time;

  // Word in flight.
  logic                  first;
  logic [ANGLE_BITS-1:0] angle_r;
  logic [TW-1:0]         dt_raw;
  logic [PW-1:0]         pos_r;
  logic [mavt_pkg::VEL_W-1:0] vel_r;

  // Input field unpacking.
  logic [mavt_pkg::ANGLE_W-1:0] angle_count;
  logic [TW-1:0]                timestamp_us;
  logic [ANGLE_BITS-1:0]        angle;
  logic                         in_accept;

  assign angle_count  = s_tdata[11:0];
  assign timestamp_us = s_tdata[43:12];
  // Only the low ANGLE_BITS bits of the sample count.
  assign angle        = ANGLE_BITS'({16'd0, angle_count});
  assign in_accept    = s_tvalid && s_tready;
  assign s_tready     = (state == mavt_pkg::T_IDLE);

  // Turn crossing test on the angle jump.
  logic signed [ANGLE_BITS:0] diff;
  logic [ANGLE_BITS:0]        jump;
  logic                       crossing;

  assign diff     = $signed({1'b0, angle}) - $signed({1'b0, last_angle});
  assign jump     = diff[ANGLE_BITS] ? (ANGLE_BITS + 1)'(-diff) : diff;
  assign crossing = primed && (CMW'(jump) > CMW'(wrap_threshold));

  // Multi-turn position from the updated turn count and the latched angle.
  logic signed [63:0] turns64;
  logic [PW-1:0]      pos;
  logic [PW:0]        dpos;
  logic               dneg;
  logic [PW:0]        dmag;
  logic [TW-1:0]      dt_use;

  assign turns64 = 64'(signed'(turns));
  assign pos     = PW'((turns64 <<< ANGLE_BITS) | 64'(angle_r));
  assign dpos    = {pos[PW-1], pos} - {last_position[PW-1], last_position};
  assign dneg    = dpos[PW];
  assign dmag    = dneg ? (PW + 1)'(~dpos + 1'b1) : dpos;
  assign dt_use  = (dt_raw != '0) ? dt_raw :
                   (default_interval_us != '0) ? TW'(default_interval_us) : TW'(1);

  // Velocity unit: scale by one million, divide by the interval, saturate.
  logic                       vel_start;
  logic                       vel_done;
  logic [mavt_pkg::VEL_W-1:0] vel_value;

  mavt_vel u_vel (
    .clk      (clk),
    .rst      (rst),
    .start    (vel_start),
    .mag      (dmag),
    .neg      (dneg),
    .dt       (dt_use),
    .done     (vel_done),
    .velocity (vel_value)
  );

  logic out_load;

  always_comb begin
    state_next = state;
    vel_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      mavt_pkg::T_IDLE: begin
        if (in_accept) state_next = mavt_pkg::T_DELTA;
      end
      mavt_pkg::T_DELTA: begin
        // The priming sample has no velocity to work out.
        if (first) begin
          state_next = mavt_pkg::T_OUT;
        end else begin
          vel_start  = 1'b1;
          state_next = mavt_pkg::T_WAIT;
        end
      end
      mavt_pkg::T_WAIT: begin
        if (vel_done) state_next = mavt_pkg::T_OUT;
      end
      mavt_pkg::T_OUT: begin
        // The output register is free once its word has been taken.
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = mavt_pkg::T_IDLE;
        end
      end
      default: begin
        state_next = mavt_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mavt_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_threshold      <= mavt_pkg::WRAP_THRESHOLD_RST;
      default_interval_us <= mavt_pkg::DEFAULT_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        mavt_pkg::REG_WRAP_THRESHOLD:   wrap_threshold      <= cfg_data[mavt_pkg::THR_W-1:0];
        mavt_pkg::REG_DEFAULT_INTERVAL: default_interval_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Tracker state. Angle, time and turns update on acceptance; the position
  // follows in the cycle after, in the delta state, once the new turn count is known.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed        <= 1'b0;
      last_angle    <= '0;
      turns         <= '0;
      last_position <= '0;
      last_time     <= '0;
    end else begin
      if (in_accept) begin
        primed     <= 1'b1;
        last_angle <= angle;
        last_time  <= timestamp_us;
        if (crossing) begin
          // A large forward jump means the angle wrapped backward, and the
          // other way round.
          turns <= diff[ANGLE_BITS] ? turns + 1'b1 : turns - 1'b1;
        end
      end
      if (state == mavt_pkg::T_DELTA) begin
        last_position <= pos;
      end
    end
  end

  // Word in flight.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      first   <= !primed;
      angle_r <= angle;
      dt_raw  <= timestamp_us - last_time;
    end
    if (state == mavt_pkg::T_DELTA) begin
      pos_r <= pos;
      vel_r <= '0;
    end
    if (state == mavt_pkg::T_WAIT && vel_done) begin
      vel_r <= vel_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'd0, vel_r, pos_r, mavt_pkg::TURN_W'(signed'(turns))};
    end
  end

  // The velocity unit finishes only while the sequencer is waiting on it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    vel_done |-> state == mavt_pkg::T_WAIT)
    else $error("velocity unit finished outside the wait state");

  // A new result shows up only from the output step.
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == mavt_pkg::T_OUT))
    else $error("result word raised without the output step");

  // One word at a time: after an acceptance the input side closes.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input accepted while a word is in flight");

endmodule

// ===== bench/multiturn_angle_velocity_tracker_core_tb.sv =====
`timescale 1ns / 1ps

module multiturn_angle_velocity_tracker_core_tb;

  // Layout of the input and result words on the stream ports.
  localparam int TS_LSB   = mavt_pkg::ANGLE_W;
  localparam int POS_LSB  = mavt_pkg::TURN_W;
  localparam int VEL_LSB  = mavt_pkg::TURN_W + mavt_pkg::POS_W;
  localparam int OUT_USED = mavt_pkg::TURN_W + mavt_pkg::POS_W + mavt_pkg::VEL_W;

  localparam longint ANGLE_SPAN = longint'(1) << mavt_pkg::ANGLE_W;
  localparam longint unsigned US_PER_SECOND = 64'd1000000;
  // Any whole quotient above this many counts per microsecond is out of range.
  localparam longint unsigned MAX_WHOLE_RATE = 64'd2147;
  localparam longint unsigned VEL_POS_LIMIT = 64'd2147483647;
  localparam longint unsigned VEL_NEG_LIMIT = 64'd2147483648;
  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic [mavt_pkg::TURN_W-1:0] turn_count;
    logic [mavt_pkg::POS_W-1:0]  position;
    logic [mavt_pkg::VEL_W-1:0]  velocity;
  } track_word_t;

  // Tracks the turn counter, position and timing of the samples that the
  // block has accepted and keeps the result words it still owes.
  class angle_track_scoreboard;
    bit                           primed;
    logic [mavt_pkg::ANGLE_W-1:0] last_angle;
    logic [mavt_pkg::TURN_W-1:0]  turns;
    longint                       last_position;
    logic [mavt_pkg::TIME_W-1:0]  last_time;
    logic [mavt_pkg::THR_W-1:0]   wrap_threshold;
    logic [mavt_pkg::INTV_W-1:0]  default_interval;
    track_word_t                  expected_words[$];
    int                           errors;

    function new();
      primed = 1'b0;
      last_angle = '0;
      turns = '0;
      last_position = 0;
      last_time = '0;
      wrap_threshold = mavt_pkg::WRAP_THRESHOLD_RST;
      default_interval = mavt_pkg::DEFAULT_INTERVAL_RST;
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic [mavt_pkg::CFG_AW-1:0] idx,
                            logic [mavt_pkg::CFG_DW-1:0] value);
      case (idx)
        mavt_pkg::REG_WRAP_THRESHOLD: begin
          wrap_threshold = value[mavt_pkg::THR_W-1:0];
        end
        mavt_pkg::REG_DEFAULT_INTERVAL: begin
          default_interval = value[mavt_pkg::INTV_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Position change over elapsed microseconds, scaled to counts per second.
    // The magnitude is divided first so the product never overflows, then the
    // sign is put back, which truncates toward zero.
    function logic [mavt_pkg::VEL_W-1:0] counts_per_second(
      longint dpos, logic [mavt_pkg::TIME_W-1:0] dt);
      bit                neg;
      longint unsigned   mag;
      longint unsigned   lim;
      longint unsigned   div;
      longint unsigned   whole;
      longint unsigned   rest;
      longint unsigned   rate;
      logic [63:0]       signed_rate;
      neg = dpos < 0;
      mag = neg ? longint'(0) - dpos : dpos;
      lim = neg ? VEL_NEG_LIMIT : VEL_POS_LIMIT;
      div = {32'd0, dt};
      whole = mag / div;
      rest = mag % div;
      if (whole > MAX_WHOLE_RATE) begin
        rate = lim;
      end else begin
        rate = whole * US_PER_SECOND + (rest * US_PER_SECOND) / div;
        if (rate > lim) begin
          rate = lim;
        end
      end
      signed_rate = neg ? 64'd0 - rate : rate;
      return signed_rate[mavt_pkg::VEL_W-1:0];
    endfunction

    function void note_sample(logic [mavt_pkg::ANGLE_W-1:0] ang,
                              logic [mavt_pkg::TIME_W-1:0] now);
      longint                      diff;
      longint unsigned             mag;
      longint                      raw_pos;
      logic [mavt_pkg::POS_W-1:0]  pos44;
      longint                      pos;
      logic [mavt_pkg::TIME_W-1:0] dt;
      track_word_t                 exp_word;
      exp_word.velocity = '0;
      if (primed) begin
        diff = longint'({52'd0, ang}) - longint'({52'd0, last_angle});
        mag = (diff < 0) ? -diff : diff;
        // A jump larger than the threshold means the angle went across zero.
        if (mag > wrap_threshold) begin
          if (diff > 0) begin
            turns = turns - 1'b1;
          end else begin
            turns = turns + 1'b1;
          end
        end
      end
      raw_pos = longint'($signed(turns)) * ANGLE_SPAN + longint'({52'd0, ang});
      pos44 = raw_pos[mavt_pkg::POS_W-1:0];
      pos = longint'($signed(pos44));
      if (primed) begin
        dt = now - last_time;
        if (dt == '0) begin
          dt = (default_interval != '0) ? {12'd0, default_interval} : 32'd1;
        end
        exp_word.velocity = counts_per_second(pos - last_position, dt);
      end
      primed = 1'b1;
      last_angle = ang;
      last_position = pos;
      last_time = now;
      exp_word.turn_count = turns;
      exp_word.position = pos44;
      expected_words.push_back(exp_word);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    task check_word(logic [111:0] w);
      track_word_t exp_word;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %h with none expected", w));
        return;
      end
      exp_word = expected_words.pop_front();
      if (w[POS_LSB-1:0] !== exp_word.turn_count) begin
        report($sformatf("turn_count %h, expected %h", w[POS_LSB-1:0], exp_word.turn_count));
      end
      if (w[POS_LSB +: mavt_pkg::POS_W] !== exp_word.position) begin
        report($sformatf("position %h, expected %h", w[POS_LSB +: mavt_pkg::POS_W],
                         exp_word.position));
      end
      if (w[VEL_LSB +: mavt_pkg::VEL_W] !== exp_word.velocity) begin
        report($sformatf("velocity %h, expected %h", w[VEL_LSB +: mavt_pkg::VEL_W],
                         exp_word.velocity));
      end
      if (w[111:OUT_USED] !== '0) begin
        report($sformatf("padding bits %h not zero", w[111:OUT_USED]));
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [47:0]                   s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [111:0]                  m_tdata;
  logic                          cfg_we = 1'b0;
  logic [mavt_pkg::CFG_AW-1:0]   cfg_addr = mavt_pkg::REG_WRAP_THRESHOLD;
  logic [mavt_pkg::CFG_DW-1:0]   cfg_data = '0;

  angle_track_scoreboard tracker_sb;

  // Idle and stall odds, in percent of cycles, for the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Where the random walk of the sample stream currently stands.
  logic [mavt_pkg::ANGLE_W-1:0] walk_angle = '0;
  logic [mavt_pkg::TIME_W-1:0]  walk_time = '0;
  logic [mavt_pkg::THR_W-1:0]   cur_threshold = mavt_pkg::WRAP_THRESHOLD_RST;

  multiturn_angle_velocity_tracker_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block stops answering.
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // The result side stalls at random with the odds of the current phase.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Both handshakes are sampled on the rising edge, before the block's own
  // registers move, so each accepted word is seen exactly once.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tracker_sb.note_sample(s_tdata[mavt_pkg::ANGLE_W-1:0],
                               s_tdata[TS_LSB +: mavt_pkg::TIME_W]);
      end
      if (m_tvalid && m_tready) begin
        tracker_sb.check_word(m_tdata);
      end
    end
  end

  // Offers one sample word and returns on the falling edge after it is taken.
  // The valid line is left high so back-to-back words need no gap.
  task automatic send_sample(logic [mavt_pkg::ANGLE_W-1:0] ang,
                             logic [mavt_pkg::TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {4'd0, now, ang};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
    walk_angle = ang;
    walk_time = now;
  endtask

  // Holds the sender off until every owed result word has been taken.
  task automatic wait_results_drained();
    s_tvalid = 1'b0;
    do begin
      @(negedge clk);
    end while (tracker_sb.pending() != 0);
  endtask

  task automatic write_register(logic [mavt_pkg::CFG_AW-1:0] idx,
                                logic [mavt_pkg::CFG_DW-1:0] value);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = value;
    tracker_sb.write_reg(idx, value);
    if (idx == mavt_pkg::REG_WRAP_THRESHOLD) begin
      cur_threshold = value[mavt_pkg::THR_W-1:0];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_tracking(logic [mavt_pkg::THR_W-1:0] thr,
                              logic [mavt_pkg::INTV_W-1:0] intv);
    wait_results_drained();
    write_register(mavt_pkg::REG_WRAP_THRESHOLD, {8'd0, thr});
    write_register(mavt_pkg::REG_DEFAULT_INTERVAL, intv);
  endtask

  // Hand-picked samples: priming, crossings both ways, the threshold edge,
  // repeated timestamps, timestamp wrap, saturation, and the register extremes
  // including a zero threshold and a zero default interval.
  task automatic run_directed();
    send_sample(12'd0, 32'd0);
    send_sample(12'd10, 32'd100);
    send_sample(12'd4095, 32'd200);
    send_sample(12'd5, 32'd200);
    send_sample(12'd4095, 32'hFFFF_FFFF);
    send_sample(12'd2000, 32'd1);
    send_sample(12'd0, 32'd2);
    send_sample(12'd3277, 32'd3);
    send_sample(12'd0, 32'd4);
    send_sample(12'd3278, 32'd5);
    set_tracking(12'd0, 20'd0);
    send_sample(12'd3278, 32'd5);
    send_sample(12'd3279, 32'd5);
    send_sample(12'd3278, 32'd6);
    set_tracking(12'd4095, 20'd1000000);
    send_sample(12'd0, 32'd6);
    send_sample(12'd4095, 32'd6);
    send_sample(12'd0, 32'd1000006);
    set_tracking(12'd1, 20'd1);
    send_sample(12'd1, 32'd1000006);
    send_sample(12'd3, 32'd1000007);
    send_sample(12'd4095, 32'd1000010);
    send_sample(12'd0, 32'h8000_0000);
  endtask

  // Mostly a plausible encoder: small angle steps that wrap across zero and
  // rising timestamps. Mixed in are repeated timestamps, jumps right around
  // the threshold, tiny intervals that force saturation, and plain noise.
  task automatic run_random(int count);
    int                           kind;
    int                           step;
    logic [mavt_pkg::ANGLE_W-1:0] ang;
    logic [mavt_pkg::TIME_W-1:0]  now;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      step = $urandom_range(300);
      now = walk_time + $urandom_range(1, 20000);
      if (kind >= 75 && kind < 85) begin
        step = int'(cur_threshold) - 2 + $urandom_range(4);
        now = walk_time + $urandom_range(1, 3000);
      end
      if ($urandom_range(1) == 1) begin
        step = -step;
      end
      ang = walk_angle + step[mavt_pkg::ANGLE_W-1:0];
      if (kind >= 65 && kind < 75) begin
        now = walk_time;
      end else if (kind >= 85 && kind < 92) begin
        ang = mavt_pkg::ANGLE_W'($urandom_range(4095));
        now = walk_time + $urandom_range(3);
      end else if (kind >= 92) begin
        ang = mavt_pkg::ANGLE_W'($urandom_range(4095));
        now = $urandom();
      end
      send_sample(ang, now);
      if ($urandom_range(63) == 0) begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    tracker_sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Phase 1: reset settings, no idling on either side.
    set_tracking(mavt_pkg::WRAP_THRESHOLD_RST, mavt_pkg::DEFAULT_INTERVAL_RST);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(300);

    // Phase 2: threshold of one, one-second default interval, idle sender.
    set_tracking(12'd1, 20'd1000000);
    send_idle_pct = 74;
    recv_stall_pct = 0;
    run_random(250);

    // Phase 3: largest threshold, one microsecond default, stalling receiver.
    set_tracking(12'd4095, 20'd1);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    run_random(250);

    // Phase 4: zero threshold and zero default interval, both sides idling.
    set_tracking(12'd0, 20'd0);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    run_random(150);

    // Phase 5: mid threshold with a random default interval, full speed.
    set_tracking(12'd2048, 20'($urandom_range(1, 1000000)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(150);

    wait_results_drained();
    // Give a stray extra word time to show up after the last one.
    repeat (80) @(negedge clk);

    if (tracker_sb.errors == 0 && tracker_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== multiturn_angle_velocity_tracker_core.f =====
hw/rtl/mavt_pkg.sv
hw/rtl/mavt_vel.sv
hw/rtl/multiturn_angle_velocity_tracker_core.sv
bench/multiturn_angle_velocity_tracker_core_tb.sv
